@@ src/dbpc_pkg.sv @@
// ----------------------------------------------------------------------------
// dbpc_pkg
// Shared types and constants of the directional beam pair counter.
// ----------------------------------------------------------------------------
package dbpc_pkg;

  localparam int unsigned Channels  = 8;
  localparam int unsigned FifoDepth = 5;
  localparam int unsigned NumFifos  = 2 * Channels;
  localparam int unsigned ChW       = $clog2(Channels);
  localparam int unsigned FifoW     = $clog2(NumFifos);
  localparam int unsigned SlotW     = $clog2(FifoDepth);
  localparam int unsigned FillW     = $clog2(FifoDepth + 1);
  localparam int unsigned MemDepth  = NumFifos * FifoDepth;
  localparam int unsigned MemW      = $clog2(MemDepth);
  localparam int unsigned CountW    = 31;
  localparam int unsigned SeenW     = 4;
  localparam int unsigned QDepth    = 2;

  typedef enum logic {
    REQ_CAPTURE = 1'b0,
    REQ_SCAN    = 1'b1
  } req_e;

  typedef enum logic [0:0] {
    REG_WINDOW  = 1'b0,
    REG_TIMEOUT = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CAP,
    ST_RD,
    ST_WAIT,
    ST_EVAL,
    ST_DONE
  } exec_state_e;

  typedef struct packed {
    req_e        req;
    logic [7:0]  outer_mask;
    logic [7:0]  inner_mask;
    logic [31:0] now;
  } cmd_t;

  typedef struct packed {
    logic [CountW-1:0] inside_count;
    logic [SeenW-1:0]  entries_seen;
    logic [SeenW-1:0]  exits_seen;
    logic [15:0]       dropped_mask;
  } res_t;

  function automatic logic [SlotW-1:0] slot_inc(logic [SlotW-1:0] s);
    logic [SlotW-1:0] r;
    if (s == SlotW'(FifoDepth - 1)) r = '0;
    else r = s + SlotW'(1);
    return r;
  endfunction

  function automatic logic [MemW-1:0] mem_addr(logic [FifoW-1:0] f,
                                               logic [SlotW-1:0] s);
    logic [MemW+3:0] a;
    a = (MemW+4)'(f) * (MemW+4)'(FifoDepth) + (MemW+4)'(s);
    return a[MemW-1:0];
  endfunction

endpackage

@@ src/dbpc_front.sv @@
// ----------------------------------------------------------------------------
// dbpc_front
// Accepts items, masks capture flags with broken-beam levels, queues commands.
// ----------------------------------------------------------------------------
module dbpc_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            req_type_i,
  input  logic [7:0]      outer_flags_i,
  input  logic [7:0]      outer_levels_i,
  input  logic [7:0]      inner_flags_i,
  input  logic [7:0]      inner_levels_i,
  input  logic [31:0]     now_ticks_i,
  output logic            cmd_valid_o,
  input  logic            cmd_ready_i,
  output dbpc_pkg::cmd_t  cmd_o
);

  dbpc_pkg::cmd_t q_mem [dbpc_pkg::QDepth];
  logic           wr_q, wr_d, rd_q, rd_d;
  logic [1:0]     cnt_q, cnt_d;
  dbpc_pkg::cmd_t in_cmd;
  logic           push, pop;

  always_comb begin
    in_cmd.req        = dbpc_pkg::req_e'(req_type_i);
    in_cmd.outer_mask = outer_flags_i & ~outer_levels_i;
    in_cmd.inner_mask = inner_flags_i & ~inner_levels_i;
    in_cmd.now        = now_ticks_i;
  end

  assign in_ready_o  = (cnt_q != 2'(dbpc_pkg::QDepth));
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_mem[rd_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_q] <= in_cmd;
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(dbpc_pkg::QDepth)) else $error("queue count overflow");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd0 |-> !pop) else $error("pop from empty queue");
  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == $past(cnt_q) + 2'd1) else $error("count slip");

endmodule

@@ src/dbpc_back.sv @@
// ----------------------------------------------------------------------------
// dbpc_back
// Executes captures and scans one channel per step over the timestamp memory.
// ----------------------------------------------------------------------------
module dbpc_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  output logic                  cmd_ready_o,
  input  dbpc_pkg::cmd_t        cmd_i,
  input  logic [31:0]           window_i,
  input  logic [31:0]           timeout_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output dbpc_pkg::res_t        res_o
);

  localparam int unsigned Ch  = dbpc_pkg::Channels;
  localparam int unsigned ChW = dbpc_pkg::ChW;
  localparam int unsigned SW  = dbpc_pkg::SlotW;
  localparam int unsigned FW  = dbpc_pkg::FillW;
  localparam int unsigned AW  = $clog2(Ch * dbpc_pkg::FifoDepth);

  logic [31:0] mem_o [Ch*dbpc_pkg::FifoDepth];
  logic [31:0] mem_i [Ch*dbpc_pkg::FifoDepth];
  logic [SW-1:0] head_q [dbpc_pkg::NumFifos];
  logic [FW-1:0] fill_q [dbpc_pkg::NumFifos];
  logic [SW-1:0] head_d [dbpc_pkg::NumFifos];
  logic [FW-1:0] fill_d [dbpc_pkg::NumFifos];

  dbpc_pkg::exec_state_e st_q, st_d;
  dbpc_pkg::cmd_t        cmd_q;
  logic [ChW-1:0]        ch_q, ch_d;
  logic [31:0]           to_q, ti_q;
  logic [dbpc_pkg::CountW-1:0] cnt_q, cnt_d;
  logic [dbpc_pkg::SeenW-1:0]  ent_q, ent_d, ext_q, ext_d;
  logic [15:0]           drop_q, drop_d;
  logic                  rv_q, rv_d;
  dbpc_pkg::res_t        res_q, res_d;
  logic                  take;

  logic [AW-1:0] ao, ai;
  logic [31:0] gap_oi, gap_io, age_o, age_i;
  logic        has_o, has_i, wr_o, wr_i, pop_o, pop_i;
  logic [SW-1:0] slot_o, slot_i;
  logic [ChW:0]  fo_idx, fi_idx;

  assign fo_idx = (ChW+1)'(ch_q);
  assign fi_idx = (ChW+1)'(Ch) + (ChW+1)'(ch_q);
  assign take   = cmd_valid_i && (st_q == dbpc_pkg::ST_IDLE);
  assign cmd_ready_o = (st_q == dbpc_pkg::ST_IDLE);
  assign res_valid_o = rv_q;
  assign res_o       = res_q;

  assign has_o  = fill_q[fo_idx] != '0;
  assign has_i  = fill_q[fi_idx] != '0;
  assign gap_oi = ti_q - to_q;
  assign gap_io = to_q - ti_q;
  assign age_o  = cmd_q.now - to_q;
  assign age_i  = cmd_q.now - ti_q;

  always_comb begin
    logic [SW+FW:0] so, si;
    so = (SW+FW+1)'(head_q[fo_idx]) + (SW+FW+1)'(fill_q[fo_idx]);
    si = (SW+FW+1)'(head_q[fi_idx]) + (SW+FW+1)'(fill_q[fi_idx]);
    if (so >= (SW+FW+1)'(dbpc_pkg::FifoDepth)) so = so - (SW+FW+1)'(dbpc_pkg::FifoDepth);
    if (si >= (SW+FW+1)'(dbpc_pkg::FifoDepth)) si = si - (SW+FW+1)'(dbpc_pkg::FifoDepth);
    slot_o = (st_q == dbpc_pkg::ST_CAP) ? SW'(so) : head_q[fo_idx];
    slot_i = (st_q == dbpc_pkg::ST_CAP) ? SW'(si) : head_q[fi_idx];
    ao = AW'((ChW+SW+3)'(ch_q) * (ChW+SW+3)'(dbpc_pkg::FifoDepth)
             + (ChW+SW+3)'(slot_o));
    ai = AW'((ChW+SW+3)'(ch_q) * (ChW+SW+3)'(dbpc_pkg::FifoDepth)
             + (ChW+SW+3)'(slot_i));
  end

  always_comb begin
    st_d = st_q;
    ch_d = ch_q;
    unique case (st_q)
      dbpc_pkg::ST_IDLE:
        if (cmd_valid_i) begin
          st_d = (cmd_i.req == dbpc_pkg::REQ_SCAN) ? dbpc_pkg::ST_RD : dbpc_pkg::ST_CAP;
          ch_d = '0;
        end
      dbpc_pkg::ST_CAP: begin
        ch_d = ch_q + ChW'(1);
        if (ch_q == ChW'(Ch - 1)) st_d = dbpc_pkg::ST_DONE;
      end
      dbpc_pkg::ST_RD:   st_d = dbpc_pkg::ST_WAIT;
      dbpc_pkg::ST_WAIT: st_d = dbpc_pkg::ST_EVAL;
      dbpc_pkg::ST_EVAL: begin
        ch_d = ch_q + ChW'(1);
        st_d = (ch_q == ChW'(Ch - 1)) ? dbpc_pkg::ST_DONE : dbpc_pkg::ST_RD;
      end
      dbpc_pkg::ST_DONE:
        if (!rv_q || res_ready_i) st_d = dbpc_pkg::ST_IDLE;
      default: st_d = dbpc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    head_d = head_q;
    fill_d = fill_q;
    cnt_d  = cnt_q;
    ent_d  = ent_q;
    ext_d  = ext_q;
    drop_d = drop_q;
    wr_o = 1'b0;
    wr_i = 1'b0;
    pop_o = 1'b0;
    pop_i = 1'b0;
    rv_d  = rv_q && !res_ready_i;
    res_d = res_q;
    if (take) begin
      ent_d = '0;
      ext_d = '0;
      drop_d = '0;
    end
    if (st_q == dbpc_pkg::ST_CAP) begin
      if (cmd_q.outer_mask[ch_q]) begin
        if (fill_q[fo_idx] == FW'(dbpc_pkg::FifoDepth)) drop_d[fo_idx] = 1'b1;
        else wr_o = 1'b1;
      end
      if (cmd_q.inner_mask[ch_q]) begin
        if (fill_q[fi_idx] == FW'(dbpc_pkg::FifoDepth)) drop_d[fi_idx] = 1'b1;
        else wr_i = 1'b1;
      end
      if (wr_o) fill_d[fo_idx] = fill_q[fo_idx] + FW'(1);
      if (wr_i) fill_d[fi_idx] = fill_q[fi_idx] + FW'(1);
    end
    if (st_q == dbpc_pkg::ST_EVAL) begin
      if (has_o && has_i) begin
        if (to_q < ti_q) begin
          if (gap_oi <= window_i) begin
            if (cnt_q != '1) cnt_d = cnt_q + 1'b1;
            ent_d = ent_q + 1'b1;
            pop_o = 1'b1;
            pop_i = 1'b1;
          end else pop_o = 1'b1;
        end else begin
          if (gap_io <= window_i) begin
            if (cnt_q != '0) cnt_d = cnt_q - 1'b1;
            ext_d = ext_q + 1'b1;
            pop_o = 1'b1;
            pop_i = 1'b1;
          end else pop_i = 1'b1;
        end
      end else begin
        pop_o = has_o && (age_o > timeout_i);
        pop_i = has_i && (age_i > timeout_i);
      end
      if (pop_o) begin
        head_d[fo_idx] = dbpc_pkg::slot_inc(head_q[fo_idx]);
        fill_d[fo_idx] = fill_q[fo_idx] - FW'(1);
      end
      if (pop_i) begin
        head_d[fi_idx] = dbpc_pkg::slot_inc(head_q[fi_idx]);
        fill_d[fi_idx] = fill_q[fi_idx] - FW'(1);
      end
    end
    if (st_q == dbpc_pkg::ST_DONE && (!rv_q || res_ready_i)) begin
      rv_d = 1'b1;
      res_d.inside_count = cnt_q;
      res_d.entries_seen = ent_q;
      res_d.exits_seen   = ext_q;
      res_d.dropped_mask = drop_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= dbpc_pkg::ST_IDLE;
      ch_q   <= '0;
      cnt_q  <= '0;
      rv_q   <= 1'b0;
      ent_q  <= '0;
      ext_q  <= '0;
      drop_q <= '0;
      for (int i = 0; i < dbpc_pkg::NumFifos; i++) begin
        head_q[i] <= '0;
        fill_q[i] <= '0;
      end
    end else begin
      st_q   <= st_d;
      ch_q   <= ch_d;
      cnt_q  <= cnt_d;
      rv_q   <= rv_d;
      ent_q  <= ent_d;
      ext_q  <= ext_d;
      drop_q <= drop_d;
      head_q <= head_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) cmd_q <= cmd_i;
    res_q  <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_o) mem_o[ao] <= cmd_q.now;
    if (st_q == dbpc_pkg::ST_RD) to_q <= mem_o[ao];
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_i[ai] <= cmd_q.now;
    if (st_q == dbpc_pkg::ST_RD) ti_q <= mem_i[ai];
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q[fo_idx] <= FW'(dbpc_pkg::FifoDepth)) else $error("fill overflow");
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv_q && !res_ready_i |=> rv_q && $stable(res_q)) else $error("result lost");
  a_seen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ent_q + ext_q <= dbpc_pkg::SeenW'(Ch)) else $error("seen overflow");
  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> st_q != dbpc_pkg::ST_IDLE) else $error("item not started");

endmodule

@@ src/directional_beam_pair_counter_top.sv @@
// The back end takes a new item only when idle, after it has finished the last one;
// it visits one channel per step, a scan needing a registered memory read per
// channel.
// A two-entry command queue lets the front accept while the back end works.
// Reset (rst_ni, async, active low): all FIFOs empty, count zero, window 2000,
// timeout 5000.
// ----------------------------------------------------------------------------
// directional_beam_pair_counter_top
// Two-beam directional passage counter with per-beam timestamp FIFOs.
// ----------------------------------------------------------------------------
module directional_beam_pair_counter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [7:0]  outer_flags_i,
  input  logic [7:0]  outer_levels_i,
  input  logic [7:0]  inner_flags_i,
  input  logic [7:0]  inner_levels_i,
  input  logic [31:0] now_ticks_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [30:0] inside_count_o,
  output logic [3:0]  entries_seen_o,
  output logic [3:0]  exits_seen_o,
  output logic [15:0] dropped_mask_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic           cmd_valid, cmd_ready;
  dbpc_pkg::cmd_t cmd;
  dbpc_pkg::res_t res;
  logic [31:0]    window_q, timeout_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q  <= 32'd2000;
      timeout_q <= 32'd5000;
    end else if (cfg_valid_i) begin
      unique case (dbpc_pkg::reg_idx_e'(cfg_index_i))
        dbpc_pkg::REG_WINDOW:  window_q  <= cfg_data_i;
        dbpc_pkg::REG_TIMEOUT: timeout_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  dbpc_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .req_type_i,
    .outer_flags_i, .outer_levels_i, .inner_flags_i, .inner_levels_i, .now_ticks_i,
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  dbpc_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .window_i(window_q), .timeout_i(timeout_q),
    .res_valid_o(out_valid_o), .res_ready_i(out_ready_i), .res_o(res)
  );

  assign inside_count_o = res.inside_count;
  assign entries_seen_o = res.entries_seen;
  assign exits_seen_o   = res.exits_seen;
  assign dropped_mask_o = res.dropped_mask;

endmodule
